// ===== hw/rtl/cyclic_chase_list_generator_unit_macros.svh =====
// Assertion macros shared by the checker of the chase list generator.
// No dependencies; include once per file that asserts.
`ifndef CYCLIC_CHASE_LIST_GENERATOR_UNIT_MACROS_SVH
`define CYCLIC_CHASE_LIST_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CCLG_ASSERT_NOW(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define CCLG_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/cclg_pkg.sv =====
// Package of the chase list generator: types, codes and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none
package cclg_pkg;

	localparam int MAX_NODES  = 1024;
	localparam int LABEL_BITS = 40;
	localparam int IDX_W      = $clog2(MAX_NODES);
	localparam int CNT_W      = IDX_W + 1;
	localparam int LBIT_W     = $clog2(LABEL_BITS);
	localparam int STRIDE_W   = 17;
	localparam int OFFS_W     = 56;
	localparam int RND_W      = 64;
	localparam int HALF_W     = LABEL_BITS / 2;
	localparam int PLO_W      = HALF_W + STRIDE_W;
	localparam int ACC_W      = PLO_W + HALF_W;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_SHUF  = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NONE  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_SEQ    = 2'd1,
		ST_POS    = 2'd2,
		ST_UNUSED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_NODE_COUNT  = 2'd0,
		CFG_NODE_STRIDE = 2'd1,
		CFG_KEEP_MASK   = 2'd2,
		CFG_KEEP_VALUE  = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SHUF = 2'd1,
		PH_DONE = 2'd2,
		PH_RSVD = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		S_IDLE, S_FILL, S_DIV, S_RD_I, S_RD_J, S_WR_I, S_WR_J,
		S_RD_P, S_RD_N, S_MAP0, S_MAP, S_MUL_LO, S_MUL_HI, S_RESP, S_RESP_LAB
	} state_t;

	typedef enum logic [2:0] {
		ADDR_CNT, ADDR_I, ADDR_J, ADDR_POS, ADDR_NXT
	} addr_sel_t;

	typedef enum logic [1:0] {
		WD_CNT, WD_RDATA, WD_HOLD
	} wdata_sel_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] random_value;
		logic [9:0]  position;
	} in_item_t;

	typedef struct packed {
		logic [39:0] node_label;
		logic [39:0] successor_label;
		logic [55:0] successor_offset;
		logic        shuffle_done;
		logic [1:0]  status;
	} out_item_t;

	typedef struct packed {
		logic             load_in;
		addr_sel_t        addr_sel;
		logic             we;
		wdata_sel_t       wsel;
		logic [IDX_W-1:0] cnt;
		logic [CNT_W-1:0] step;
		logic             div_step;
		logic             cap_a;
		logic             cap_b;
		logic             map_step;
		logic             mul_lo;
		logic             mul_hi;
		logic             res_load;
		logic             res_lab;
		status_t          res_status;
		logic             res_done;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] eff_count;
		logic             pos_big;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cyclic_chase_list_generator_unit.sv =====
// Top level of the chase list generator: controller plus datapath.
// Depends on cclg_pkg, cclg_ctrl, cclg_datapath.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------
//  request   | start / busy         | req    (in_item_t)
//  result    | done (one-cycle)     | result (out_item_t)
//  config    | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// From one accept to the earliest next accept, a shuffle item runs the
// bit-serial remainder in the datapath, the swap through the single store
// port, a load of the result and then done; a read item runs two store reads,
// one capture, the label deposit, two multiply stages, a load of the result
// and then done; a start item runs an identity sweep over all 1024 store
// entries, one per cycle, then the result. Other items go straight to the
// result.
// Reset sets the controller and the config registers to defaults; the store
// is written by the start sweep before it is ever read.
// done is high for one cycle; the receiver cannot stall, and busy falls in
// that same cycle so the next item may start at once.
`default_nettype none
module cyclic_chase_list_generator_unit import cclg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  in_item_t         req,
	output logic             done,
	output out_item_t        result,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [39:0] cfg_data
);

	cmd_t       cmd;
	dp_status_t dst;

	// config writes are taken at any time; the user keeps them to idle periods
	assign cfg_ready = 1'b1;

	cclg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.dst      (dst),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	cclg_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.dst       (dst),
		.result    (result)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/cclg_ctrl.sv =====
// Controller of the chase list generator: sequencing, build phase, step count.
// Depends on cclg_pkg.
`default_nettype none
module cclg_ctrl import cclg_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] req_type,
	input  dp_status_t      dst,
	output cmd_t            cmd,
	output logic            busy,
	output logic            done
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] step_q, step_d;
	phase_t           phase_q, phase_d;
	status_t          st_q, st_d;
	logic             done_q;
	logic             accept;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			step_q  <= '0;
			phase_q <= PH_IDLE;
			st_q    <= ST_OK;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			step_q  <= step_d;
			phase_q <= phase_d;
			st_q    <= st_d;
			done_q  <= cmd.res_load;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		step_d  = step_q;
		phase_d = phase_q;
		st_d    = st_q;
		cmd            = '0;
		cmd.addr_sel   = ADDR_CNT;
		cmd.wsel       = WD_CNT;
		cmd.res_status = st_q;
		cmd.cnt        = cnt_q;
		cmd.step       = step_q;
		cmd.load_in    = accept;
		case (state_q)
			S_IDLE: begin
				cnt_d = '0;
				if (accept) begin
					st_d    = ST_OK;
					state_d = S_RESP;
					case (req_type_t'(req_type))
						REQ_START: begin
							step_d  = dst.eff_count - CNT_W'(1);
							phase_d = PH_SHUF;
							state_d = S_FILL;
						end
						REQ_SHUF: begin
							if (phase_q == PH_SHUF && step_q != '0) begin
								state_d = S_DIV;
							end else begin
								st_d = ST_SEQ;
							end
						end
						REQ_READ: begin
							if (phase_q != PH_DONE) begin
								st_d = ST_SEQ;
							end else if (dst.pos_big) begin
								st_d = ST_POS;
							end else begin
								state_d = S_RD_P;
							end
						end
						default: st_d = ST_SEQ;
					endcase
				end
			end
			S_FILL: begin
				cmd.we = 1'b1;
				cnt_d  = cnt_q + IDX_W'(1);
				if (cnt_q == IDX_W'(MAX_NODES - 1)) begin
					state_d = S_RESP;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + IDX_W'(1);
				if (cnt_q == IDX_W'(RND_W - 1)) begin
					cnt_d   = '0;
					state_d = S_RD_I;
				end
			end
			S_RD_I: begin
				cmd.addr_sel = ADDR_I;
				state_d      = S_RD_J;
			end
			S_RD_J: begin
				cmd.addr_sel = ADDR_J;
				cmd.cap_a    = 1'b1;
				state_d      = S_WR_I;
			end
			S_WR_I: begin
				cmd.addr_sel = ADDR_I;
				cmd.we       = 1'b1;
				cmd.wsel     = WD_RDATA;
				state_d      = S_WR_J;
			end
			S_WR_J: begin
				cmd.addr_sel = ADDR_J;
				cmd.we       = 1'b1;
				cmd.wsel     = WD_HOLD;
				step_d       = step_q - CNT_W'(1);
				if (step_q == CNT_W'(1)) begin
					phase_d = PH_DONE;
				end
				state_d = S_RESP;
			end
			S_RD_P: begin
				cmd.addr_sel = ADDR_POS;
				state_d      = S_RD_N;
			end
			S_RD_N: begin
				cmd.addr_sel = ADDR_NXT;
				cmd.cap_a    = 1'b1;
				state_d      = S_MAP0;
			end
			S_MAP0: begin
				cmd.cap_b = 1'b1;
				cnt_d     = '0;
				state_d   = S_MAP;
			end
			S_MAP: begin
				cmd.map_step = 1'b1;
				cnt_d        = cnt_q + IDX_W'(1);
				if (cnt_q == IDX_W'(LABEL_BITS - 1)) begin
					state_d = S_MUL_LO;
				end
			end
			S_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = S_MUL_HI;
			end
			S_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = S_RESP_LAB;
			end
			S_RESP: begin
				cmd.res_load = 1'b1;
				cmd.res_done = (phase_q == PH_DONE);
				state_d      = S_IDLE;
			end
			S_RESP_LAB: begin
				cmd.res_load = 1'b1;
				cmd.res_lab  = 1'b1;
				cmd.res_done = (phase_q == PH_DONE);
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cclg_datapath.sv =====
// Datapath of the chase list generator: config registers, order store,
// bit-serial remainder, label deposit, offset multiply. Depends on cclg_pkg.
`default_nettype none
module cclg_datapath import cclg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [39:0] cfg_data,
	input  in_item_t         req,
	input  cmd_t             cmd,
	output dp_status_t       dst,
	output out_item_t        result
);

	logic [CNT_W-1:0]      node_count_q;
	logic [STRIDE_W-1:0]   node_stride_q;
	logic [LABEL_BITS-1:0] keep_mask_q, keep_value_q;

	logic [IDX_W-1:0]      mem [MAX_NODES];
	logic [IDX_W-1:0]      rdata_q;
	logic [IDX_W-1:0]      addr, wdata, idx_i, nxt;
	logic [RND_W-1:0]      rnd_q;
	logic [IDX_W-1:0]      pos_q, rem_q;
	logic [CNT_W-1:0]      trial, diff;
	logic [IDX_W-1:0]      idx_a_q, idx_b_q;
	logic [LABEL_BITS-1:0] lab_a_q, lab_b_q, nl, sl;
	logic [LBIT_W-1:0]     bidx;
	logic [PLO_W-1:0]      plo_q;
	logic [ACC_W-1:0]      acc_q;
	logic [CNT_W-1:0]      eff;
	logic [CNT_W-1:0]      pos_inc;
	out_item_t             res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q  <= CNT_W'(2);
			node_stride_q <= STRIDE_W'(64);
			keep_mask_q   <= '0;
			keep_value_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_NODE_COUNT:  node_count_q  <= cfg_data[CNT_W-1:0];
				CFG_NODE_STRIDE: node_stride_q <= cfg_data[STRIDE_W-1:0];
				CFG_KEEP_MASK:   keep_mask_q   <= cfg_data;
				CFG_KEEP_VALUE:  keep_value_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (node_count_q < CNT_W'(2)) begin
			eff = CNT_W'(2);
		end else if (node_count_q > CNT_W'(MAX_NODES)) begin
			eff = CNT_W'(MAX_NODES);
		end else begin
			eff = node_count_q;
		end
	end

	assign dst.eff_count = eff;
	assign dst.pos_big   = ({1'b0, req.position} >= eff);

	// addresses
	assign idx_i   = IDX_W'(cmd.step - CNT_W'(1));
	assign pos_inc = {1'b0, pos_q} + CNT_W'(1);
	assign nxt     = (pos_inc == eff) ? '0 : pos_inc[IDX_W-1:0];

	always_comb begin
		case (cmd.addr_sel)
			ADDR_I:   addr = idx_i;
			ADDR_J:   addr = rem_q;
			ADDR_POS: addr = pos_q;
			ADDR_NXT: addr = nxt;
			default:  addr = cmd.cnt;
		endcase
		case (cmd.wsel)
			WD_RDATA: wdata = rdata_q;
			WD_HOLD:  wdata = idx_a_q;
			default:  wdata = cmd.cnt;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	// restoring remainder, one dividend bit per cycle
	assign trial = {rem_q, rnd_q[RND_W-1]};
	assign diff  = trial - cmd.step;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			rnd_q <= req.random_value;
			pos_q <= req.position;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rnd_q <= rnd_q << 1;
			rem_q <= (trial >= cmd.step) ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
		end
	end

	// bit deposit into the free label bits
	assign bidx = cmd.cnt[LBIT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			idx_a_q <= rdata_q;
		end else if (cmd.map_step && !keep_mask_q[bidx]) begin
			idx_a_q <= idx_a_q >> 1;
		end
		if (cmd.cap_b) begin
			idx_b_q <= rdata_q;
			lab_a_q <= '0;
			lab_b_q <= '0;
		end else if (cmd.map_step && !keep_mask_q[bidx]) begin
			idx_b_q       <= idx_b_q >> 1;
			lab_a_q[bidx] <= idx_a_q[0];
			lab_b_q[bidx] <= idx_b_q[0];
		end
	end

	assign nl = lab_a_q | (keep_mask_q & keep_value_q);
	assign sl = lab_b_q | (keep_mask_q & keep_value_q);

	always_ff @(posedge clk) begin
		if (cmd.mul_lo) begin
			plo_q <= PLO_W'(sl[HALF_W-1:0]) * PLO_W'(node_stride_q);
		end
		if (cmd.mul_hi) begin
			acc_q <= (ACC_W'(PLO_W'(sl[LABEL_BITS-1:HALF_W]) * PLO_W'(node_stride_q))
				<< HALF_W) + ACC_W'(plo_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q.shuffle_done <= cmd.res_done;
			res_q.status       <= cmd.res_status;
			if (cmd.res_lab) begin
				res_q.node_label       <= nl;
				res_q.successor_label  <= sl;
				res_q.successor_offset <= (acc_q[ACC_W-1:OFFS_W] != '0) ? '1
					: acc_q[OFFS_W-1:0];
			end else begin
				res_q.node_label       <= '0;
				res_q.successor_label  <= '0;
				res_q.successor_offset <= '0;
			end
		end
	end

	assign result = res_q;

endmodule
`default_nettype wire

// ===== hw/rtl/cclg_checker.sv =====
// Port-level checker for the chase list generator, bound to the top level.
// Depends on cclg_pkg and the macros header.
`default_nettype none
`include "cyclic_chase_list_generator_unit_macros.svh"
module cclg_checker import cclg_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic cfg_valid,
	input wire logic cfg_ready
);

	`CCLG_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`CCLG_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)
	`CCLG_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done)
	`CCLG_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind cyclic_chase_list_generator_unit cclg_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
`default_nettype wire

// ===== tb/sv/cclg_scoreboard.sv =====
`timescale 1ns / 1ps
// Checker for the chase list generator: watches the request, result and config
// channels, predicts every result and compares it field by field. Needs cclg_pkg.
module cclg_scoreboard import cclg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  in_item_t         req,
	input  logic             done,
	input  out_item_t        result,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [39:0]      cfg_data,
	output int               fail_count,
	output int               outstanding
);

	logic [9:0]  perm [MAX_NODES];
	logic [10:0] steps_left;
	phase_t      phase;
	logic [10:0] count_reg;
	logic [16:0] stride_reg;
	logic [39:0] keep_mask;
	logic [39:0] keep_value;
	out_item_t   expected_q [$];

	function automatic int clamped_count();
		if (count_reg < 2) return 2;
		if (count_reg > MAX_NODES) return MAX_NODES;
		return int'(count_reg);
	endfunction

	// deposit index bits, LSB first, into the label bits clear in keep_mask
	function automatic logic [39:0] deposit_label(logic [9:0] idx);
		logic [39:0] lab;
		int k;
		lab = '0;
		k = 0;
		for (int b = 0; b < LABEL_BITS; b++) begin
			if (!keep_mask[b]) begin
				if (k < IDX_W) lab[b] = idx[k];
				k++;
			end
		end
		return lab | (keep_mask & keep_value);
	endfunction

	task automatic predict_item(input in_item_t it, output out_item_t r);
		int n;
		int i;
		int j;
		int nxt;
		logic [9:0]  tmp;
		logic [63:0] prod;
		r = '0;
		n = clamped_count();
		case (it.req_type)
			REQ_START: begin
				for (int k = 0; k < MAX_NODES; k++) perm[k] = k[9:0];
				steps_left = 11'(n - 1);
				phase = (steps_left == 0) ? PH_DONE : PH_SHUF;
			end
			REQ_SHUF: begin
				if (phase == PH_SHUF && steps_left > 0) begin
					i = int'(steps_left) - 1;
					j = int'(it.random_value % (64'(i) + 64'd1));
					tmp = perm[i];
					perm[i] = perm[j];
					perm[j] = tmp;
					steps_left = 11'(i);
					if (i == 0) phase = PH_DONE;
				end else begin
					r.status = ST_SEQ;
				end
			end
			REQ_READ: begin
				if (phase != PH_DONE) begin
					r.status = ST_SEQ;
				end else if (it.position >= n) begin
					r.status = ST_POS;
				end else begin
					nxt = (it.position + 1 == n) ? 0 : it.position + 1;
					r.node_label = deposit_label(perm[it.position]);
					r.successor_label = deposit_label(perm[nxt]);
					prod = 64'(r.successor_label) * 64'(stride_reg);
					r.successor_offset = (prod > 64'hFF_FFFF_FFFF_FFFF) ? '1 : prod[55:0];
				end
			end
			default: r.status = ST_SEQ;
		endcase
		r.shuffle_done = (phase == PH_DONE);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		out_item_t new_r;
		if (!arst_n) begin
			steps_left = '0;
			phase = PH_IDLE;
			count_reg = 11'd2;
			stride_reg = 17'd64;
			keep_mask = '0;
			keep_value = '0;
			expected_q.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			// check the result first: the next item may be accepted on the same edge
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result with no item outstanding");
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_q.pop_front();
					if (result.node_label !== exp_r.node_label)
						$error("node_label exp %h got %h", exp_r.node_label, result.node_label);
					if (result.successor_label !== exp_r.successor_label)
						$error("successor_label exp %h got %h", exp_r.successor_label,
							result.successor_label);
					if (result.successor_offset !== exp_r.successor_offset)
						$error("successor_offset exp %h got %h", exp_r.successor_offset,
							result.successor_offset);
					if (result.shuffle_done !== exp_r.shuffle_done)
						$error("shuffle_done exp %b got %b", exp_r.shuffle_done,
							result.shuffle_done);
					if (result.status !== exp_r.status)
						$error("status exp %0d got %0d", exp_r.status, result.status);
					if (result !== exp_r) fail_count <= fail_count + 1;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_NODE_COUNT:  count_reg = cfg_data[10:0];
					CFG_NODE_STRIDE: stride_reg = cfg_data[16:0];
					CFG_KEEP_MASK:   keep_mask = cfg_data;
					CFG_KEEP_VALUE:  keep_value = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				predict_item(req, new_r);
				expected_q.push_back(new_r);
			end
			outstanding <= expected_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_cyclic_chase_list_generator_unit.sv =====
`timescale 1ns / 1ps
// Testbench top of the chase list generator: drives requests and config writes
// and gives the verdict. Needs cclg_pkg, cclg_scoreboard and the unit itself.
module tb_cyclic_chase_list_generator_unit;
	import cclg_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_item_t    req;
	logic        done;
	out_item_t   result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [39:0] cfg_data;
	int          fail_count;
	int          outstanding;
	int          sent;
	int          cycles;
	bit          steady;
	logic [10:0] count_now;

	cyclic_chase_list_generator_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	cclg_scoreboard chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: fails the simulation if the cycle counter passes its limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [39:0] rand40();
		return {8'($urandom), $urandom};
	endfunction

	function automatic int clamp_count(logic [10:0] c);
		if (c < 2) return 2;
		if (c > MAX_NODES) return MAX_NODES;
		return c;
	endfunction

	// Present one item after a random gap; return on the edge that takes it.
	// start stays high when the next item follows with no gap.
	task automatic send(req_type_t t, logic [63:0] rnd, logic [9:0] pos);
		int gap;
		gap = steady ? 0 : $urandom_range(9);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= '{req_type: t, random_value: rnd, position: pos};
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	// Drop start and let every outstanding result come back.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [39:0] data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_NODE_COUNT) count_now = data[10:0];
	endtask

	// One build: new settings, start, a shuffle with some noise (full for counts up to 130), then reads.
	task automatic run_chain();
		int n;
		int steps;
		int k;
		int nr;
		steady = ($urandom_range(3) == 0);
		case ($urandom_range(7))
			0: cfg_write(CFG_NODE_COUNT, 40'($urandom_range(1)));
			1: cfg_write(CFG_NODE_COUNT, 40'($urandom_range(2047, 300)));
			2: cfg_write(CFG_NODE_COUNT, 40'($urandom_range(120, 25)));
			default: cfg_write(CFG_NODE_COUNT, 40'($urandom_range(24, 2)));
		endcase
		if ($urandom_range(3) != 0) begin
			case ($urandom_range(4))
				0: cfg_write(CFG_NODE_STRIDE, 40'd0);
				1: cfg_write(CFG_NODE_STRIDE, 40'd1);
				2: cfg_write(CFG_NODE_STRIDE, 40'd65536);
				3: cfg_write(CFG_NODE_STRIDE, 40'h1FFFF);
				default: cfg_write(CFG_NODE_STRIDE, 40'($urandom_range(131071)));
			endcase
		end
		if ($urandom_range(3) != 0) begin
			case ($urandom_range(3))
				0: cfg_write(CFG_KEEP_MASK, '0);
				1: cfg_write(CFG_KEEP_MASK, '1);
				2: cfg_write(CFG_KEEP_MASK, rand40());
				default: cfg_write(CFG_KEEP_MASK, rand40() & rand40());
			endcase
		end
		if ($urandom_range(3) != 0)
			cfg_write(CFG_KEEP_VALUE, $urandom_range(3) == 0 ? '1 : rand40());
		n = clamp_count(count_now);
		// large counts: cut the shuffle short, reads then see it unfinished
		steps = (n > 130) ? 20 : n - 1;
		send(REQ_START, rand64(), 10'($urandom));
		k = 0;
		while (k < steps) begin
			if ($urandom_range(19) == 0)
				send($urandom_range(1) ? REQ_READ : REQ_NONE, rand64(), 10'($urandom));
			if ($urandom_range(60) == 0) begin
				send(REQ_START, rand64(), 10'($urandom));
				k = 0;
			end
			send(REQ_SHUF, $urandom_range(3) == 0 ? 64'($urandom_range(15)) : rand64(),
				10'($urandom));
			k++;
		end
		if ($urandom_range(4) == 0)
			cfg_write(CFG_NODE_COUNT, 40'($urandom_range(n + 3, 2)));
		n = clamp_count(count_now);
		nr = $urandom_range(12, 3);
		for (int r = 0; r < nr; r++) begin
			if ($urandom_range(9) == 0)
				send(REQ_SHUF, rand64(), 10'($urandom));
			send(REQ_READ, rand64(),
				$urandom_range(5) == 0 ? 10'($urandom) : 10'($urandom_range(n - 1)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_NODE_COUNT;
		cfg_data = '0;
		cycles = 0;
		sent = 0;
		steady = 1'b0;
		count_now = 11'd2;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// out of sequence before any start, reserved type, then a count-2 build
		send(REQ_READ, '0, 10'd0);
		send(REQ_SHUF, '1, 10'd0);
		send(REQ_NONE, '1, '1);
		send(REQ_START, '0, '0);
		send(REQ_READ, '0, 10'd0);
		send(REQ_SHUF, '1, 10'd0);
		send(REQ_SHUF, '1, 10'd0);
		send(REQ_READ, '0, 10'd0);
		send(REQ_READ, '0, 10'd1);
		send(REQ_READ, '0, 10'd2);
		send(REQ_READ, '0, '1);

		// count below range, widest stride, every label bit held
		cfg_write(CFG_NODE_COUNT, 40'd0);
		cfg_write(CFG_NODE_STRIDE, 40'h1FFFF);
		cfg_write(CFG_KEEP_MASK, '1);
		cfg_write(CFG_KEEP_VALUE, '1);
		send(REQ_START, '1, '1);
		send(REQ_SHUF, '0, '0);
		send(REQ_READ, '0, 10'd0);
		send(REQ_READ, '0, 10'd1);

		// count above range saturates; read before shuffle completes
		cfg_write(CFG_NODE_COUNT, 40'd2047);
		cfg_write(CFG_KEEP_MASK, '0);
		cfg_write(CFG_NODE_STRIDE, 40'd0);
		send(REQ_START, '0, '0);
		send(REQ_READ, '0, 10'd1023);

		// count changed after start: steps follow the old count
		cfg_write(CFG_NODE_COUNT, 40'd5);
		cfg_write(CFG_NODE_STRIDE, 40'd65536);
		send(REQ_START, '0, '0);
		for (int s = 0; s < 4; s++) send(REQ_SHUF, rand64(), '0);
		cfg_write(CFG_NODE_COUNT, 40'd8);
		send(REQ_READ, '0, 10'd7);
		send(REQ_READ, '0, 10'd4);
		cfg_write(CFG_NODE_COUNT, 40'd3);
		send(REQ_READ, '0, 10'd2);
		send(REQ_READ, '0, 10'd4);

		while (sent < 850) run_chain();

		wait_idle();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== cyclic_chase_list_generator_unit.f =====
+incdir+hw/rtl
hw/rtl/cclg_pkg.sv
hw/rtl/cclg_ctrl.sv
hw/rtl/cclg_datapath.sv
hw/rtl/cyclic_chase_list_generator_unit.sv
hw/rtl/cclg_checker.sv
tb/sv/cclg_scoreboard.sv
tb/sv/tb_cyclic_chase_list_generator_unit.sv
